// ----- hdl/dchk_pkg.sv -----
package dchk_pkg;

  localparam int DEPTH_DEF      = 1024;
  localparam int VALUE_BITS_DEF = 16;
  localparam int ITEM_VALUE_W   = 16;
  localparam int VERDICT_W      = 3;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_IMPOSSIBLE = 3'd0,
    VERDICT_STACK      = 3'd1,
    VERDICT_QUEUE      = 3'd2,
    VERDICT_PRIORITY   = 3'd3,
    VERDICT_UNSURE     = 3'd4
  } verdict_t;

  typedef struct packed {
    logic stack;
    logic fifo;
    logic heap;
  } flags_t;

  function automatic verdict_t verdict_of(flags_t f);
    logic [1:0] sum;
    verdict_t   v;
    sum = 2'(f.stack) + 2'(f.fifo) + 2'(f.heap);
    if (sum == 2'd0) begin
      v = VERDICT_IMPOSSIBLE;
    end else if (sum > 2'd1) begin
      v = VERDICT_UNSURE;
    end else if (f.stack) begin
      v = VERDICT_STACK;
    end else if (f.fifo) begin
      v = VERDICT_QUEUE;
    end else begin
      v = VERDICT_PRIORITY;
    end
    return v;
  endfunction

endpackage

// ----- hdl/dchk_if.sv -----
interface dchk_in_if;
  logic                               valid;
  logic                               ready;
  logic                               action;
  logic [dchk_pkg::ITEM_VALUE_W-1:0]  item_value;
  logic                               start_trace;

  modport source (output valid, action, item_value, start_trace, input ready);
  modport sink   (input valid, action, item_value, start_trace, output ready);
endinterface

interface dchk_out_if;
  logic                            valid;
  logic                            ready;
  logic                            maybe_stack;
  logic                            maybe_fifo;
  logic                            maybe_max_heap;
  logic [dchk_pkg::VERDICT_W-1:0]  verdict;
  logic                            overflow;

  modport source (output valid, maybe_stack, maybe_fifo, maybe_max_heap, verdict, overflow,
                  input ready);
  modport sink   (input valid, maybe_stack, maybe_fifo, maybe_max_heap, verdict, overflow,
                  output ready);
endinterface

// ----- hdl/dchk_ram.sv -----
module dchk_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/container_discipline_checker_core.sv -----
// insert: S_FINISH registers the result, then the next item is accepted in S_IDLE
// remove: S_RD_LAST, S_SCAN over the live entries, S_FIN_REM, then S_FINISH as for insert;
//   the single read port reads the newest entry, then walks every live entry once,
//   compacting behind a match in the same pass; a stalled result holds the next item back
// remove from an empty store: straight to S_FINISH, as for insert
// reset (synchronous, rst_n low): store empty, all three flags set, no result pending;
//   the entry memory is not cleared and only live positions feed the result
module container_discipline_checker_core #(
  parameter int DEPTH      = dchk_pkg::DEPTH_DEF,
  parameter int VALUE_BITS = dchk_pkg::VALUE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  dchk_in_if.sink    in_item,
  dchk_out_if.source out_item
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int UB = (VALUE_BITS < dchk_pkg::ITEM_VALUE_W) ? VALUE_BITS
                                                             : dchk_pkg::ITEM_VALUE_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_LAST,
    S_SCAN,
    S_FIN_REM,
    S_FINISH
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CW-1:0]           count_r, count_nxt;
  dchk_pkg::flags_t        flags_r, flags_nxt;
  logic [VALUE_BITS-1:0]   val_r, val_nxt;
  logic [AW-1:0]           newest_r, newest_nxt;
  logic [AW-1:0]           idx_r, idx_nxt;
  logic                    last_hit_r, last_hit_nxt;
  logic                    found_r, found_nxt;
  logic [VALUE_BITS-1:0]   max_r, max_nxt;
  logic                    ovf_r, ovf_nxt;

  logic                    out_valid_r, out_valid_nxt;
  dchk_pkg::flags_t        out_flags_r, out_flags_nxt;
  dchk_pkg::verdict_t      out_verdict_r, out_verdict_nxt;
  logic                    out_ovf_r, out_ovf_nxt;

  logic                    accept;
  logic [VALUE_BITS-1:0]   in_val;
  logic [CW-1:0]           count_eff;
  dchk_pkg::flags_t        flags_eff;

  logic                    mem_we;
  logic [AW-1:0]           mem_waddr;
  logic [VALUE_BITS-1:0]   mem_wdata;
  logic [AW-1:0]           mem_raddr;
  logic [VALUE_BITS-1:0]   mem_rdata;

  dchk_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (DEPTH)
  ) u_entries (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign in_item.ready = (state_r == S_IDLE);
  assign accept        = in_item.valid && in_item.ready;
  assign in_val        = VALUE_BITS'(in_item.item_value[UB-1:0]);
  assign count_eff     = in_item.start_trace ? '0 : count_r;
  assign flags_eff     = in_item.start_trace ? 3'b111 : flags_r;

  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    flags_nxt       = flags_r;
    val_nxt         = val_r;
    newest_nxt      = newest_r;
    idx_nxt         = idx_r;
    last_hit_nxt    = last_hit_r;
    found_nxt       = found_r;
    max_nxt         = max_r;
    ovf_nxt         = ovf_r;
    out_valid_nxt   = out_valid_r && !out_item.ready;
    out_flags_nxt   = out_flags_r;
    out_verdict_nxt = out_verdict_r;
    out_ovf_nxt     = out_ovf_r;
    mem_we          = 1'b0;
    mem_waddr       = count_eff[AW-1:0];
    mem_wdata       = in_val;
    mem_raddr       = AW'(idx_r + 1'b1);

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          val_nxt   = in_val;
          ovf_nxt   = 1'b0;
          count_nxt = count_eff;
          flags_nxt = flags_eff;
          state_nxt = S_FINISH;
          if (in_item.action == dchk_pkg::ACT_INSERT) begin
            if (count_eff == CW'(DEPTH)) begin
              ovf_nxt = 1'b1;
            end else begin
              mem_we    = 1'b1;
              count_nxt = count_eff + 1'b1;
            end
          end else if (count_eff == '0) begin
            flags_nxt = '0;
          end else begin
            newest_nxt = AW'(count_eff - 1'b1);
            mem_raddr  = AW'(count_eff - 1'b1);
            state_nxt  = S_RD_LAST;
          end
        end
      end

      S_RD_LAST: begin
        // newest entry is on the read port now
        last_hit_nxt = (mem_rdata == val_r);
        found_nxt    = 1'b0;
        idx_nxt      = '0;
        mem_raddr    = '0;
        state_nxt    = S_SCAN;
      end

      S_SCAN: begin
        if (idx_r == '0) begin
          max_nxt = mem_rdata;
          if (mem_rdata != val_r) begin
            flags_nxt.fifo = 1'b0;
          end
        end else if (mem_rdata > max_r) begin
          max_nxt = mem_rdata;
        end
        // behind the deleted entry everything slides down by one
        if (found_r) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(idx_r - 1'b1);
          mem_wdata = mem_rdata;
        end else if (!last_hit_r && idx_r != newest_r && mem_rdata == val_r) begin
          found_nxt = 1'b1;
        end
        if (idx_r == newest_r) begin
          state_nxt = S_FIN_REM;
        end else begin
          idx_nxt = AW'(idx_r + 1'b1);
        end
      end

      S_FIN_REM: begin
        if (!last_hit_r) begin
          flags_nxt.stack = 1'b0;
        end
        if (max_r != val_r) begin
          flags_nxt.heap = 1'b0;
        end
        if (last_hit_r || found_r) begin
          count_nxt = count_r - 1'b1;
        end
        state_nxt = S_FINISH;
      end

      S_FINISH: begin
        if (!out_valid_r || out_item.ready) begin
          out_valid_nxt   = 1'b1;
          out_flags_nxt   = flags_r;
          out_verdict_nxt = dchk_pkg::verdict_of(flags_r);
          out_ovf_nxt     = ovf_r;
          state_nxt       = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      flags_r     <= 3'b111;
      out_valid_r <= 1'b0;
      last_hit_r  <= 1'b0;
      found_r     <= 1'b0;
      ovf_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      flags_r     <= flags_nxt;
      out_valid_r <= out_valid_nxt;
      last_hit_r  <= last_hit_nxt;
      found_r     <= found_nxt;
      ovf_r       <= ovf_nxt;
    end
    val_r         <= val_nxt;
    newest_r      <= newest_nxt;
    idx_r         <= idx_nxt;
    max_r         <= max_nxt;
    out_flags_r   <= out_flags_nxt;
    out_verdict_r <= out_verdict_nxt;
    out_ovf_r     <= out_ovf_nxt;
  end

  assign out_item.valid          = out_valid_r;
  assign out_item.maybe_stack    = out_flags_r.stack;
  assign out_item.maybe_fifo     = out_flags_r.fifo;
  assign out_item.maybe_max_heap = out_flags_r.heap;
  assign out_item.verdict        = out_verdict_r;
  assign out_item.overflow       = out_ovf_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("live count above store depth");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (idx_r <= newest_r))
    else $error("scan index past newest entry");

  a_remove_shrinks_by_one: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN_REM) |=>
      (count_r == $past(count_r)) || (count_r == CW'($past(count_r) - 1'b1)))
    else $error("remove changed live count by more than one");

  a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> ((state_r == S_IDLE) && accept) || ((state_r == S_SCAN) && found_r))
    else $error("entry write outside insert or compaction");

  a_compact_needs_miss: assert property (@(posedge clk) disable iff (!rst_n)
    found_r && (state_r == S_SCAN) |-> !last_hit_r)
    else $error("compaction started although newest entry matched");

endmodule
